[rtl/mlcd_pkg.sv]
// ----------------------------------------------------------------------------
// mlcd_pkg
// shared types and constants of the memory lcd frame controller
// ----------------------------------------------------------------------------
`default_nettype none

package mlcd_pkg;

	// panel command bytes
	localparam logic [7:0] CMD_WRITE = 8'h01;
	localparam logic [7:0] CMD_VCOM  = 8'h02;
	localparam logic [7:0] CMD_CLEAR = 8'h04;
	localparam logic [7:0] FILL_BYTE = 8'hff;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	typedef enum logic [1:0] {
		OP_DRAW    = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_REFRESH = 2'd2,
		OP_TICK    = 2'd3
	} mlcd_op_t;

	// what the datapath puts into the output buffer
	typedef enum logic [2:0] {
		PUSH_CMD_CLEAR  = 3'd0,
		PUSH_CLEAR_TAIL = 3'd1,
		PUSH_CMD_WRITE  = 3'd2,
		PUSH_LINE_NUM   = 3'd3,
		PUSH_STORE      = 3'd4,
		PUSH_LINE_END   = 3'd5,
		PUSH_FRAME_END  = 3'd6
	} mlcd_push_t;

	typedef struct packed {
		logic       accept;
		logic       draw_rd;
		logic       draw_wr;
		logic       sweep;
		logic       sweep_start;
		logic       push;
		mlcd_push_t push_sel;
		logic       vcom_toggle;
		logic       refresh_start;
		logic       refresh_stop;
		logic       byte_next;
		logic       line_next;
		logic       tick_rd;
	} mlcd_cmd_t;

	typedef struct packed {
		logic refresh_active;
		logic frame_done;
		logic byte_zero;
		logic byte_in_range;
		logic sweep_done;
	} mlcd_status_t;

endpackage : mlcd_pkg

`default_nettype wire

[rtl/mlcd_out_buf.sv]
// ----------------------------------------------------------------------------
// mlcd_out_buf
// two-entry output buffer between the datapath and the master stream
// ----------------------------------------------------------------------------
`default_nettype none

module mlcd_out_buf import mlcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] push_byte,
	input  wire logic       push_last,
	output logic            full,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // spi_byte[7:0]
	output logic            m_tlast    // transfer_last
);

	logic [8:0] entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full     = (count_q == 2'd2);
	assign m_tvalid = (count_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = entry_q[rd_ptr_q][7:0];
	assign m_tlast  = entry_q[rd_ptr_q][8];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= {push_last, push_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule : mlcd_out_buf

`default_nettype wire

[rtl/mlcd_datapath.sv]
// ----------------------------------------------------------------------------
// mlcd_datapath
// frame store, rotation, address generation, refresh counters and vcom
// ----------------------------------------------------------------------------
`default_nettype none

module mlcd_datapath import mlcd_pkg::*; #(
	parameter int PANEL_WIDTH  = 160,
	parameter int PANEL_HEIGHT = 68
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire mlcd_cmd_t cmd,
	output mlcd_status_t status,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata,
	input  wire logic [7:0] in_pos_x,
	input  wire logic [7:0] in_pos_y,
	input  wire logic       in_color,
	output logic [7:0]  push_byte,
	output logic        push_last
);

	localparam int LINE_BYTES  = PANEL_WIDTH / 8;
	localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int PX_W        = $clog2(PANEL_WIDTH);
	localparam int POS_W       = 8 + PX_W;
	localparam int BYTE_W      = $clog2(LINE_BYTES + 2);
	localparam int TICK_W      = 8 + $clog2(LINE_BYTES + 1);

	logic [7:0]        frame_store_q [STORE_BYTES];
	logic [7:0]        rdata_q;
	logic [1:0]        rotation_q;
	logic              vcom_q;
	logic              active_q;
	logic [7:0]        line_q;
	logic [BYTE_W-1:0] byte_q;
	logic [ADDR_W-1:0] sweep_cnt_q;

	logic [PX_W-1:0]   px_q;
	logic [7:0]        py_q;
	logic              ok_q;
	logic              color_q;
	logic [ADDR_W-1:0] draw_addr_q;
	logic [2:0]        bit_q;

	// rotation, bounds check
	logic [9:0]  x_ext;
	logic [9:0]  y_ext;
	logic        ok_d;
	logic [9:0]  px_d;
	logic [7:0]  py_d;

	assign x_ext = {2'b00, in_pos_x};
	assign y_ext = {2'b00, in_pos_y};

	always_comb begin
		ok_d = 1'b0;
		px_d = x_ext;
		py_d = in_pos_y;
		case (rotation_q)
			2'd0: begin
				ok_d = (x_ext < 10'(PANEL_WIDTH)) && (y_ext < 10'(PANEL_HEIGHT));
				px_d = x_ext;
				py_d = in_pos_y;
			end
			2'd1: begin
				ok_d = (x_ext < 10'(PANEL_HEIGHT)) && (y_ext < 10'(PANEL_WIDTH));
				px_d = 10'(PANEL_WIDTH - 1) - y_ext;
				py_d = in_pos_x;
			end
			2'd2: begin
				ok_d = (x_ext < 10'(PANEL_WIDTH)) && (y_ext < 10'(PANEL_HEIGHT));
				px_d = 10'(PANEL_WIDTH - 1) - x_ext;
				py_d = 8'(PANEL_HEIGHT - 1) - in_pos_y;
			end
			default: begin
				ok_d = (x_ext < 10'(PANEL_HEIGHT)) && (y_ext < 10'(PANEL_WIDTH));
				px_d = y_ext;
				py_d = 8'(PANEL_HEIGHT - 1) - in_pos_x;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q    <= px_d[PX_W-1:0];
			py_q    <= py_d;
			ok_q    <= ok_d;
			color_q <= in_color;
		end
	end

	// linear pixel position, byte address
	logic [POS_W-1:0]  pos_lin;
	logic [ADDR_W-1:0] draw_addr;
	logic [TICK_W-1:0] tick_lin;
	logic [ADDR_W-1:0] tick_addr;

	assign pos_lin   = POS_W'(py_q) * POS_W'(PANEL_WIDTH) + POS_W'(px_q);
	assign draw_addr = pos_lin[3 +: ADDR_W];
	assign tick_lin  = TICK_W'(line_q) * TICK_W'(LINE_BYTES) + TICK_W'(byte_q)
		- TICK_W'(1);
	assign tick_addr = tick_lin[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.draw_rd) begin
			draw_addr_q <= draw_addr;
			bit_q       <= px_q[2:0];
		end
	end

	// frame store
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic [7:0]        bit_mask;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	assign bit_mask  = 8'h01 << bit_q;
	assign mem_we    = cmd.sweep || (cmd.draw_wr && ok_q);
	assign mem_waddr = cmd.sweep ? sweep_cnt_q : draw_addr_q;
	assign mem_wdata = cmd.sweep ? FILL_BYTE
		: (color_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask));
	assign mem_re    = cmd.draw_rd || cmd.tick_rd;
	assign mem_raddr = cmd.draw_rd ? draw_addr : tick_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_store_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= frame_store_q[mem_raddr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q  <= 2'd0;
			vcom_q      <= 1'b1;
			active_q    <= 1'b0;
			line_q      <= 8'd0;
			byte_q      <= '0;
			sweep_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				rotation_q <= cfg_wdata;
			end
			if (cmd.vcom_toggle) begin
				vcom_q <= ~vcom_q;
			end
			if (cmd.sweep_start) begin
				sweep_cnt_q <= '0;
			end else if (cmd.sweep) begin
				sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
			end
			if (cmd.refresh_start || cmd.refresh_stop) begin
				active_q <= cmd.refresh_start;
				line_q   <= 8'd0;
				byte_q   <= '0;
			end else if (cmd.line_next) begin
				line_q <= line_q + 8'd1;
				byte_q <= '0;
			end else if (cmd.byte_next) begin
				byte_q <= byte_q + BYTE_W'(1);
			end
		end
	end

	assign status.refresh_active = active_q;
	assign status.frame_done     = (line_q >= 8'(PANEL_HEIGHT));
	assign status.byte_zero      = (byte_q == '0);
	assign status.byte_in_range  = (byte_q <= BYTE_W'(LINE_BYTES));
	assign status.sweep_done     = (sweep_cnt_q == ADDR_W'(STORE_BYTES - 1));

	// result byte
	logic [7:0] vcom_byte;

	assign vcom_byte = vcom_q ? CMD_VCOM : ZERO_BYTE;

	always_comb begin
		push_byte = ZERO_BYTE;
		push_last = 1'b0;
		unique case (cmd.push_sel)
			PUSH_CMD_CLEAR:  push_byte = vcom_byte | CMD_CLEAR;
			PUSH_CLEAR_TAIL: push_last = 1'b1;
			PUSH_CMD_WRITE:  push_byte = vcom_byte | CMD_WRITE;
			PUSH_LINE_NUM:   push_byte = line_q + 8'd1;
			PUSH_STORE:      push_byte = rdata_q;
			PUSH_LINE_END:   push_byte = ZERO_BYTE;
			PUSH_FRAME_END:  push_last = 1'b1;
			default:         push_byte = ZERO_BYTE;
		endcase
	end

endmodule : mlcd_datapath

`default_nettype wire

[rtl/mlcd_ctrl.sv]
// ----------------------------------------------------------------------------
// mlcd_ctrl
// controller state machine: item decode, store sweep, byte stream sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module mlcd_ctrl import mlcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_op,
	output logic            in_ready,
	input  wire logic       buf_full,
	input  wire mlcd_status_t status,
	output mlcd_cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_CLR_CMD,
		ST_CLR_TAIL,
		ST_REF_CMD,
		ST_TICK,
		ST_TICK_OUT
	} state_t;

	state_t   state_q;
	state_t   state_d;
	mlcd_op_t op;

	assign op       = mlcd_op_t'(in_op);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (op)
						OP_DRAW:    state_d = ST_DRAW_RD;
						OP_CLEAR: begin
							cmd.refresh_stop = 1'b1;
							state_d          = ST_CLR_CMD;
						end
						OP_REFRESH: state_d = ST_REF_CMD;
						OP_TICK:    state_d = status.refresh_active ? ST_TICK : ST_IDLE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_DRAW_RD: begin
				cmd.draw_rd = 1'b1;
				state_d     = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				cmd.draw_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_CLR_CMD: begin
				cmd.push_sel = PUSH_CMD_CLEAR;
				if (!buf_full) begin
					cmd.push        = 1'b1;
					cmd.vcom_toggle = 1'b1;
					state_d         = ST_CLR_TAIL;
				end
			end
			ST_CLR_TAIL: begin
				cmd.push_sel = PUSH_CLEAR_TAIL;
				if (!buf_full) begin
					cmd.push        = 1'b1;
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end
			end
			ST_REF_CMD: begin
				cmd.push_sel = PUSH_CMD_WRITE;
				if (!buf_full) begin
					cmd.push          = 1'b1;
					cmd.vcom_toggle   = 1'b1;
					cmd.refresh_start = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (status.frame_done) begin
					cmd.push_sel = PUSH_FRAME_END;
					if (!buf_full) begin
						cmd.push         = 1'b1;
						cmd.refresh_stop = 1'b1;
						state_d          = ST_IDLE;
					end
				end else if (status.byte_zero) begin
					cmd.push_sel = PUSH_LINE_NUM;
					if (!buf_full) begin
						cmd.push      = 1'b1;
						cmd.byte_next = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (status.byte_in_range) begin
					cmd.tick_rd = 1'b1;
					state_d     = ST_TICK_OUT;
				end else begin
					cmd.push_sel = PUSH_LINE_END;
					if (!buf_full) begin
						cmd.push      = 1'b1;
						cmd.line_next = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			ST_TICK_OUT: begin
				cmd.push_sel = PUSH_STORE;
				if (!buf_full) begin
					cmd.push      = 1'b1;
					cmd.byte_next = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

endmodule : mlcd_ctrl

`default_nettype wire

[rtl/memory_lcd_frame_controller_core.sv]
// ----------------------------------------------------------------------------
// memory_lcd_frame_controller_core
// one-bit framebuffer for a memory lcd, emits the panel's command byte stream
// draw: store read, then write; start refresh: push write command; tick:
//   push line number, line end or frame end, or store read, then push byte
// clear pushes command and tail, then sweeps the store, one byte per cycle:
//   PANEL_WIDTH * PANEL_HEIGHT / 8 bytes (1360 at defaults), no item taken
// one item at a time; results wait in a two-entry buffer on the master side
// reset: vcom 1, rotation 0, no refresh; the same store sweep runs after reset
// ----------------------------------------------------------------------------
`default_nettype none

module memory_lcd_frame_controller_core import mlcd_pkg::*; #(
	parameter int PANEL_WIDTH  = 160,
	parameter int PANEL_HEIGHT = 68
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// rotation register
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // pos_x[7:0], pos_y[15:8], color[16], zero fill
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // spi_byte[7:0]
	output logic             m_tlast    // transfer_last
);

	mlcd_cmd_t    cmd;
	mlcd_status_t status;
	logic         buf_full;
	logic [7:0]   push_byte;
	logic         push_last;

	// sequencing: decode, wait for buffer room, sweep control
	mlcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.buf_full (buf_full),
		.status   (status),
		.cmd      (cmd)
	);

	// frame store, rotation, counters, result byte selection
	mlcd_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_pos_x  (s_tdata[7:0]),
		.in_pos_y  (s_tdata[15:8]),
		.in_color  (s_tdata[16]),
		.push_byte (push_byte),
		.push_last (push_last)
	);

	// results are decoupled from the consumer here, clear pushes two
	mlcd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.push),
		.push_byte (push_byte),
		.push_last (push_last),
		.full      (buf_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// no item taken while the store is being filled
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !s_tready)
		else $error("item accepted during store sweep");

	// a push never overruns the output buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !buf_full)
		else $error("push into full output buffer");

	// a clear abandons any refresh in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_CLEAR) |=> !status.refresh_active)
		else $error("refresh still active after clear");

endmodule : memory_lcd_frame_controller_core

`default_nettype wire
